// ----- rtl/swtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package swtf_pkg;

  // Word format of every port: signed, FB fraction bits.
  localparam int DW = 32;
  localparam int FB = 16;

  // Full product of two words.
  localparam int PW = 2 * DW;
  // Rounded magnitude of a word product after the fraction shift.
  localparam int HUW = PW - FB - 1;
  // Signed rounded word product.
  localparam int HVW = HUW + 1;
  // Signed difference of two rounded products.
  localparam int JW = HVW + 1;
  localparam int JMW = JW - 1;

  // Gravity in the word format, rounded to nearest.
  localparam int GW = 20;
  localparam logic [GW-1:0] GRAV_Q = GW'(((981 << FB) + 50) / 100);

  // g*h product, its rounded value and the radicand of the root.
  localparam int XPW = GW + DW - 1;
  localparam int XW = XPW + 1 - FB;
  localparam int RADW = XW + FB;
  localparam int ROOTW = RADW / 2;
  localparam int REMW = ROOTW + 3;
  localparam int SQ_BITS = 2;
  localparam int SQ_STAGES = ROOTW / SQ_BITS;

  // Wave speed: magnitude of a velocity plus a root.
  localparam int CW = DW + 1;

  // Partial products of the two wide multiplications.
  localparam int SPL = 24;
  localparam int MPW = HUW + DW;
  localparam int DPW = CW + JMW;

  // Pipeline depth from the accepting edge to the output register.
  localparam int LAT = SQ_STAGES + 7;

endpackage
`default_nettype wire

// ----- rtl/shallow_water_transverse_flux_core.sv -----
// Throughput: one beat per cycle; busy is never raised, as the receiver cannot stall.
// The thirteen-stage root pipeline (two result bits per stage) sets the depth.
// Reset is synchronous and active low; it clears the valid bits of every stage,
// so no result strobe appears until beats have been accepted after reset.
`timescale 1ns / 1ps
`default_nettype none
module shallow_water_transverse_flux_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic signed [swtf_pkg::DW-1:0]    in_vel_normal_left,
  input  wire logic signed [swtf_pkg::DW-1:0]    in_vel_normal_right,
  input  wire logic signed [swtf_pkg::DW-1:0]    in_vel_trans_left,
  input  wire logic signed [swtf_pkg::DW-1:0]    in_vel_trans_right,
  input  wire logic signed [swtf_pkg::DW-1:0]    in_depth_left,
  input  wire logic signed [swtf_pkg::DW-1:0]    in_depth_right,
  output      logic                              out_valid,
  output      logic signed [swtf_pkg::DW-1:0]    out_flux,
  output      logic                              out_saturated
);
  import swtf_pkg::*;

  localparam int NV = LAT - 1;

  function automatic logic [HUW-1:0] rnd_mag(input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    m = m + PW'(1 << (FB - 1));
    return m[PW-2:FB];
  endfunction

  function automatic logic [DW-1:0] abs_w(input logic signed [DW-1:0] a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  // Valid and dry flags, index i holds stage i+1.
  logic vld_r [NV];
  logic dry_r [NV];

  // Stage 1: raw products.
  logic signed [PW-1:0] p_hu_r [2];
  logic signed [PW-1:0] p_hv_r [2];
  logic [XPW-1:0]       p_g_r  [2];
  logic [DW-1:0]        absu1_r [2];
  logic [DW-1:0]        vmag1_r [2];
  logic                 vneg1_r [2];

  // Stage 2: rounded products.
  logic [HUW-1:0]        hu_mag_r [2];
  logic                  m_neg2_r [2];
  logic signed [HVW-1:0] hv_r [2];
  logic [XW-1:0]         x_r  [2];
  logic [DW-1:0]         vmag2_r [2];

  // Stage 3: partial products and jump.
  logic [SPL+DW-1:0]     mpp_lo_r [2];
  logic [MPW-SPL-1:0]    mpp_hi_r [2];
  logic                  m_neg3_r [2];
  logic signed [JW-1:0]  jump_r;

  // Stage 4: full products, jump magnitude.
  logic [MPW-1:0]        msum_full_r [2];
  logic                  m_neg4_r [2];

  // Stage 5 and 6.
  logic signed [PW-1:0]  m_r [2];
  logic signed [PW-1:0]  msum_d_r [LAT-6];

  // Jump magnitude and sign, index 0 is stage 4.
  logic [JMW-1:0]        jmag_d_r [LAT-7];
  logic                  jneg_d_r [LAT-7];

  // Velocity magnitudes held for the wave speed, index 0 is stage 2.
  logic [DW-1:0]         absu_d_r [2][SQ_STAGES+1];

  // Root pipeline, index k is stage k+3.
  logic [REMW-1:0]       sq_rem_r [2][SQ_STAGES];
  logic [ROOTW-1:0]      sq_q_r   [2][SQ_STAGES];
  logic [RADW-1:0]       sq_rad_r [2][SQ_STAGES];

  // Dissipation path.
  logic [CW-1:0]         c_r;
  logic                  jneg17_r, jneg18_r;
  logic [SPL+CW-1:0]     dpp_lo_r;
  logic [DPW-SPL-1:0]    dpp_hi_r;
  logic [DPW-1:0]        dsum_r;
  logic signed [PW-1:0]  diss_r;

  logic                  out_valid_r;
  logic signed [DW-1:0]  out_flux_r;
  logic                  out_sat_r;

  // Next values.
  logic signed [DW-1:0]  in_u [2];
  logic signed [DW-1:0]  in_v [2];
  logic signed [DW-1:0]  in_h [2];
  logic [REMW-1:0]       sq_rem_nxt [2][SQ_STAGES];
  logic [ROOTW-1:0]      sq_q_nxt   [2][SQ_STAGES];
  logic [RADW-1:0]       sq_rad_nxt [2][SQ_STAGES];
  logic [CW-1:0]         c_nxt;
  logic signed [PW-1:0]  m_nxt [2];
  logic signed [PW-1:0]  diss_nxt;
  logic signed [DW-1:0]  flux_nxt;
  logic                  sat_nxt;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_u[0] = in_vel_normal_left;
  assign in_u[1] = in_vel_normal_right;
  assign in_v[0] = in_vel_trans_left;
  assign in_v[1] = in_vel_trans_right;
  assign in_h[0] = in_depth_left;
  assign in_h[1] = in_depth_right;

  // Restoring square root, two result bits per stage.
  always_comb begin
    logic [REMW-1:0]  rem;
    logic [REMW-1:0]  rem2;
    logic [REMW-1:0]  trial;
    logic [ROOTW-1:0] q;
    logic [RADW-1:0]  rad;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        if (k == 0) begin
          rem = '0;
          q   = '0;
          rad = {x_r[s], FB'(0)};
        end else begin
          rem = sq_rem_r[s][k-1];
          q   = sq_q_r[s][k-1];
          rad = sq_rad_r[s][k-1];
        end
        for (int j = 0; j < SQ_BITS; j++) begin
          rem2  = {rem[REMW-3:0], rad[RADW-1:RADW-2]};
          rad   = {rad[RADW-3:0], 2'b00};
          trial = {1'b0, q, 2'b01};
          if (rem2 >= trial) begin
            rem = rem2 - trial;
            q   = {q[ROOTW-2:0], 1'b1};
          end else begin
            rem = rem2;
            q   = {q[ROOTW-2:0], 1'b0};
          end
        end
        sq_rem_nxt[s][k] = rem;
        sq_q_nxt[s][k]   = q;
        sq_rad_nxt[s][k] = rad;
      end
    end
  end

  always_comb begin
    logic [MPW:0]     ms;
    logic [DPW:0]     ds;
    logic [CW-1:0]    cl;
    logic [CW-1:0]    cr;
    logic signed [PW-1:0] res;
    for (int s = 0; s < 2; s++) begin
      ms = {1'b0, msum_full_r[s]} + (MPW+1)'(1 << FB);
      m_nxt[s] = m_neg4_r[s] ? -PW'(ms[MPW:FB+1]) : PW'(ms[MPW:FB+1]);
    end
    cl = CW'(absu_d_r[0][SQ_STAGES]) + CW'(sq_q_r[0][SQ_STAGES-1]);
    cr = CW'(absu_d_r[1][SQ_STAGES]) + CW'(sq_q_r[1][SQ_STAGES-1]);
    c_nxt = (cl >= cr) ? cl : cr;
    ds = {1'b0, dsum_r} + (DPW+1)'(1 << FB);
    diss_nxt = jneg18_r ? -PW'(ds[PW+FB:FB+1]) : PW'(ds[PW+FB:FB+1]);
    res = msum_d_r[LAT-7] - diss_r;
    sat_nxt = 1'b0;
    flux_nxt = res[DW-1:0];
    if (!res[PW-1] && (|res[PW-2:DW-1])) begin
      flux_nxt = {1'b0, {(DW-1){1'b1}}};
      sat_nxt  = 1'b1;
    end else if (res[PW-1] && !(&res[PW-2:DW-1])) begin
      flux_nxt = {1'b1, {(DW-1){1'b0}}};
      sat_nxt  = 1'b1;
    end
    if (dry_r[NV-1]) begin
      flux_nxt = '0;
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [XPW:0] xs;
    logic [HVW-1:0] hvm;
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < NV; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[NV-1];
    end

    dry_r[0] <= !((!in_h[0][DW-1] && (|in_h[0])) || (!in_h[1][DW-1] && (|in_h[1])));
    for (int i = 1; i < NV; i++) begin
      dry_r[i] <= dry_r[i-1];
    end

    for (int s = 0; s < 2; s++) begin
      // Stage 1.
      p_hu_r[s]  <= PW'(in_h[s]) * PW'(in_u[s]);
      p_hv_r[s]  <= PW'(in_h[s]) * PW'(in_v[s]);
      p_g_r[s]   <= XPW'(GRAV_Q) * XPW'(in_h[s][DW-1] ? '0 : in_h[s][DW-2:0]);
      absu1_r[s] <= abs_w(in_u[s]);
      vmag1_r[s] <= abs_w(in_v[s]);
      vneg1_r[s] <= in_v[s][DW-1];
      // Stage 2.
      hu_mag_r[s] <= rnd_mag(p_hu_r[s]);
      m_neg2_r[s] <= p_hu_r[s][PW-1] ^ vneg1_r[s];
      hvm = {1'b0, rnd_mag(p_hv_r[s])};
      hv_r[s] <= p_hv_r[s][PW-1] ? -hvm : hvm;
      xs = {1'b0, p_g_r[s]} + (XPW+1)'(1 << (FB - 1));
      x_r[s] <= xs[XPW:FB];
      vmag2_r[s] <= vmag1_r[s];
      absu_d_r[s][0] <= absu1_r[s];
      for (int k = 1; k <= SQ_STAGES; k++) begin
        absu_d_r[s][k] <= absu_d_r[s][k-1];
      end
      // Stage 3.
      mpp_lo_r[s] <= (SPL+DW)'(hu_mag_r[s][SPL-1:0]) * (SPL+DW)'(vmag2_r[s]);
      mpp_hi_r[s] <= (MPW-SPL)'(hu_mag_r[s][HUW-1:SPL]) * (MPW-SPL)'(vmag2_r[s]);
      m_neg3_r[s] <= m_neg2_r[s];
      // Stage 4.
      msum_full_r[s] <= (MPW'(mpp_hi_r[s]) << SPL) + MPW'(mpp_lo_r[s]);
      m_neg4_r[s] <= m_neg3_r[s];
      // Stage 5.
      m_r[s] <= m_nxt[s];
      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_rem_r[s][k] <= sq_rem_nxt[s][k];
        sq_q_r[s][k]   <= sq_q_nxt[s][k];
        sq_rad_r[s][k] <= sq_rad_nxt[s][k];
      end
    end

    jump_r <= JW'(hv_r[1]) - JW'(hv_r[0]);
    jneg_d_r[0] <= jump_r[JW-1];
    jmag_d_r[0] <= jump_r[JW-1] ? JMW'(-jump_r) : JMW'(jump_r);
    for (int i = 1; i < LAT - 7; i++) begin
      jneg_d_r[i] <= jneg_d_r[i-1];
      jmag_d_r[i] <= jmag_d_r[i-1];
    end

    msum_d_r[0] <= m_r[0] + m_r[1];
    for (int i = 1; i < LAT - 6; i++) begin
      msum_d_r[i] <= msum_d_r[i-1];
    end

    c_r      <= c_nxt;
    dpp_lo_r <= (SPL+CW)'(jmag_d_r[LAT-8][SPL-1:0]) * (SPL+CW)'(c_r);
    dpp_hi_r <= (DPW-SPL)'(jmag_d_r[LAT-8][JMW-1:SPL]) * (DPW-SPL)'(c_r);
    jneg17_r <= jneg_d_r[LAT-8];
    dsum_r   <= (DPW'(dpp_hi_r) << SPL) + DPW'(dpp_lo_r);
    jneg18_r <= jneg17_r;
    diss_r   <= diss_nxt;

    out_flux_r <= flux_nxt;
    out_sat_r  <= sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_flux      = out_flux_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire

// ----- tb/shallow_water_transverse_flux_core_tb.sv -----
`timescale 1ns / 1ps
module shallow_water_transverse_flux_core_tb;
  import swtf_pkg::*;

  localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint I64_MIN = -64'sh7fff_ffff_ffff_ffff - 1;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [DW-1:0] un_l, un_r, vt_l, vt_r, h_l, h_r;
  } cell_face_t;

  typedef struct packed {
    logic signed [DW-1:0] flux;
    logic                 sat;
  } face_flux_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DW-1:0] in_vel_normal_left = '0, in_vel_normal_right = '0;
  logic signed [DW-1:0] in_vel_trans_left = '0, in_vel_trans_right = '0;
  logic signed [DW-1:0] in_depth_left = '0, in_depth_right = '0;
  logic out_valid;
  logic signed [DW-1:0] out_flux;
  logic out_saturated;

  cell_face_t pending_faces[$];
  face_flux_t expected_fluxes[$];
  int sender_idle_pct = 18;
  bit failed = 1'b0;
  int quiet_cycles = 0;
  bit clip_flag;

  shallow_water_transverse_flux_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vel_normal_left(in_vel_normal_left), .in_vel_normal_right(in_vel_normal_right),
    .in_vel_trans_left(in_vel_trans_left), .in_vel_trans_right(in_vel_trans_right),
    .in_depth_left(in_depth_left), .in_depth_right(in_depth_right),
    .out_valid(out_valid), .out_flux(out_flux), .out_saturated(out_saturated)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Rounded fixed-point product, ties away from zero, saturated to 64 bits.
  function automatic longint qmul(longint a, longint b, int s);
    logic [127:0] m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = (m + (128'd1 << (s - 1))) >> s;
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) begin
        clip_flag = 1'b1;
        return I64_MIN;
      end
      return -longint'(m[63:0]);
    end
    if (m >= 128'h8000_0000_0000_0000) begin
      clip_flag = 1'b1;
      return I64_MAX;
    end
    return longint'(m[63:0]);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] r;
    r = 65'(a) + 65'(b);
    if (r > 65'(I64_MAX)) begin
      clip_flag = 1'b1;
      return I64_MAX;
    end
    if (r < 65'(I64_MIN)) begin
      clip_flag = 1'b1;
      return I64_MIN;
    end
    return longint'(r);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    logic signed [64:0] r;
    r = 65'(a) - 65'(b);
    if (r > 65'(I64_MAX)) begin
      clip_flag = 1'b1;
      return I64_MAX;
    end
    if (r < 65'(I64_MIN)) begin
      clip_flag = 1'b1;
      return I64_MIN;
    end
    return longint'(r);
  endfunction

  // Gravity wave speed; a negative depth counts as dry here only.
  function automatic longint gravity_speed(longint h);
    longint       x;
    logic [127:0] rad, t;
    logic [63:0]  r;
    x = qmul(longint'(GRAV_Q), h > 0 ? h : 0, FB);
    rad = 128'(unsigned'(x)) << FB;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = 128'(r | (64'd1 << b));
      if (t * t <= rad) r = t[63:0];
    end
    return longint'(r);
  endfunction

  function automatic face_flux_t predict_flux(cell_face_t f);
    face_flux_t res;
    longint ul, ur, vl, vr, hl, hr, cl, cr, c, ml, mr, jump, diss, acc;
    ul = f.un_l; ur = f.un_r; vl = f.vt_l; vr = f.vt_r; hl = f.h_l; hr = f.h_r;
    clip_flag = 1'b0;
    acc = 0;
    if (hl > 0 || hr > 0) begin
      cl = sat_add(ul < 0 ? sat_sub(0, ul) : ul, gravity_speed(hl));
      cr = sat_add(ur < 0 ? sat_sub(0, ur) : ur, gravity_speed(hr));
      c = cl >= cr ? cl : cr;
      ml = qmul(qmul(hl, ul, FB), vl, FB + 1);
      mr = qmul(qmul(hr, ur, FB), vr, FB + 1);
      jump = sat_sub(qmul(hr, vr, FB), qmul(hl, vl, FB));
      diss = qmul(c, jump, FB + 1);
      acc = sat_sub(sat_add(ml, mr), diss);
      if (acc > 64'sh7fff_ffff) begin
        acc = 64'sh7fff_ffff;
        clip_flag = 1'b1;
      end
      if (acc < -64'sh8000_0000) begin
        acc = -64'sh8000_0000;
        clip_flag = 1'b1;
      end
    end
    res.flux = acc[DW-1:0];
    res.sat = clip_flag;
    return res;
  endfunction

  function automatic logic [DW-1:0] rand_word(bit realistic);
    case ($urandom_range(realistic ? 3 : 5, 0))
      0: return $urandom_range(32'h0008_0000, 0);
      1: return -$urandom_range(32'h0008_0000, 0);
      2: return $urandom_range(32'h0100_0000, 0);
      3: return -$urandom_range(32'h0100_0000, 0);
      4: return $urandom();
      default: return $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_depth();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return -$urandom_range(32'h0004_0000, 1);
      2: return $urandom();
      default: return $urandom_range(32'h0020_0000, 1);
    endcase
  endfunction

  // Driver: a beat is taken at a rising edge with start high and busy low.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && busy) begin
        // Hold the offered beat.
      end else if (pending_faces.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
          begin
        cell_face_t f;
        f = pending_faces.pop_front();
        start <= 1'b1;
        in_vel_normal_left <= f.un_l; in_vel_normal_right <= f.un_r;
        in_vel_trans_left <= f.vt_l; in_vel_trans_right <= f.vt_r;
        in_depth_left <= f.h_l; in_depth_right <= f.h_r;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted beats and checks every strobed result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        cell_face_t f;
        f = {in_vel_normal_left, in_vel_normal_right, in_vel_trans_left,
             in_vel_trans_right, in_depth_left, in_depth_right};
        expected_fluxes.push_back(predict_flux(f));
      end
      if (out_valid) begin
        if (expected_fluxes.size() == 0) begin
          $display("%0t: unexpected result flux=%h sat=%b", $realtime, out_flux, out_saturated);
          failed = 1'b1;
        end else begin
          face_flux_t e;
          e = expected_fluxes.pop_front();
          if (out_flux !== e.flux) begin
            $display("%0t: flux expected %h actual %h", $realtime, e.flux, out_flux);
            failed = 1'b1;
          end
          if (out_saturated !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $realtime, e.sat, out_saturated);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("FAIL shallow_water_transverse_flux_core");
        $finish;
      end
    end
  end

  task automatic add_face(logic [DW-1:0] ul, ur, vl, vr, hl, hr);
    cell_face_t f;
    f = {ul, ur, vl, vr, hl, hr};
    pending_faces.push_back(f);
  endtask

  task automatic add_random_faces(int n);
    for (int i = 0; i < n; i++) begin
      bit real_ish;
      real_ish = $urandom_range(9, 0) < 8;
      add_face(rand_word(real_ish), rand_word(real_ish), rand_word(real_ish),
               rand_word(real_ish), real_ish ? rand_depth() : rand_word(0),
               real_ish ? rand_depth() : rand_word(0));
    end
  endtask

  task automatic drain_phase();
    while (pending_faces.size() != 0 || start) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats: dry faces, one-sided negative depth, extremes, clipping.
    add_face(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0003_0000, '0, '0);
    add_face(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h8000_0000, 32'hffff_ffff);
    add_face(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
             32'h0001_0000, 32'h0002_0000);
    add_face(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'hfffe_0000,
             32'hffff_0000, 32'h0002_0000);
    add_face(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'hfffe_0000,
             32'h0003_0000, 32'h8000_0000);
    add_face(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff);
    add_face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h8000_0000);
    add_face(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff);
    add_face('0, '0, '0, '0, 32'h0000_0001, '0);
    add_face(32'hffff_ffff, 32'h0000_0001, 32'h0000_8000, 32'hffff_8000,
             32'h0000_0001, 32'h0000_0001);
    add_face('0, '0, 32'h0100_0000, 32'hff00_0000, 32'h0100_0000, 32'h0100_0000);
    add_face(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
             32'h5555_5555, 32'h2aaa_aaaa);
    add_random_faces(280);
    drain_phase();
    sender_idle_pct = 60;
    add_random_faces(280);
    drain_phase();
    sender_idle_pct = 0;
    add_random_faces(280);
    drain_phase();
    while (expected_fluxes.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (failed) begin
      $display("FAIL shallow_water_transverse_flux_core");
    end else begin
      $display("PASS shallow_water_transverse_flux_core");
    end
    $finish;
  end

endmodule
